// File: design/slps_pkg.sv
// Shared types and constants for the status LED pattern sequencer.
package slps_pkg;

  localparam int unsigned TIMER_BITS_DEFAULT = 16;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_BOOT_BREATH    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CONNECTED_HOLD = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_BLINK     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FAST_BLINK     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UPDATE_IVL     = 3'd4;

  localparam logic [15:0] BOOT_BREATH_RST    = 16'd5000;
  localparam logic [15:0] CONNECTED_HOLD_RST = 16'd3000;
  localparam logic [15:0] SLOW_BLINK_RST     = 16'd500;
  localparam logic [15:0] FAST_BLINK_RST     = 16'd250;
  localparam logic [9:0]  UPDATE_IVL_RST     = 10'd50;

  localparam logic [15:0] HUE_RED    = 16'd0;
  localparam logic [15:0] HUE_YELLOW = 16'd10922;
  localparam logic [15:0] HUE_GREEN  = 16'd21845;
  localparam logic [15:0] HUE_BLUE   = 16'd43690;
  localparam logic [15:0] HUE_STEP   = 16'd256;
  localparam logic [16:0] HUE_WRAP   = 17'd65535;
  localparam logic [7:0]  FULL_8     = 8'd255;
  localparam logic [7:0]  BREATH_STEP = 8'd5;

  typedef enum logic [3:0] {
    MODE_OFF           = 4'd0,
    MODE_BOOTING       = 4'd1,
    MODE_CONNECTING    = 4'd2,
    MODE_CONNECTED     = 4'd3,
    MODE_WIFI_ERR      = 4'd4,
    MODE_OTA           = 4'd5,
    MODE_CARD_READING  = 4'd6,
    MODE_CARD_VALID    = 4'd7,
    MODE_CARD_INVALID  = 4'd8,
    MODE_SERVER_ERR    = 4'd9
  } mode_t;

  typedef struct packed {
    logic [15:0] boot_breath_ms;
    logic [15:0] connected_hold_ms;
    logic [15:0] slow_blink_ms;
    logic [15:0] fast_blink_ms;
    logic [9:0]  update_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic        led_on;
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  level;
    logic [3:0]  current_mode;
  } res_t;

endpackage

// File: design/slps_cfg_regs.sv
// Configuration register file for the status LED pattern sequencer.
module slps_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [slps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [slps_pkg::CFG_DATA_W-1:0]     cfg_data,
  output slps_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_breath_ms     <= slps_pkg::BOOT_BREATH_RST;
      cfg.connected_hold_ms  <= slps_pkg::CONNECTED_HOLD_RST;
      cfg.slow_blink_ms      <= slps_pkg::SLOW_BLINK_RST;
      cfg.fast_blink_ms      <= slps_pkg::FAST_BLINK_RST;
      cfg.update_interval_ms <= slps_pkg::UPDATE_IVL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slps_pkg::REG_BOOT_BREATH:    cfg.boot_breath_ms     <= cfg_data;
        slps_pkg::REG_CONNECTED_HOLD: cfg.connected_hold_ms  <= cfg_data;
        slps_pkg::REG_SLOW_BLINK:     cfg.slow_blink_ms      <= cfg_data;
        slps_pkg::REG_FAST_BLINK:     cfg.fast_blink_ms      <= cfg_data;
        slps_pkg::REG_UPDATE_IVL:     cfg.update_interval_ms <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/slps_core.sv
// Pattern state and single-pass update logic for one word.
module slps_core #(
  parameter int unsigned TIMER_BITS = slps_pkg::TIMER_BITS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            req_type,
  input  logic [3:0]      new_mode,
  input  slps_pkg::cfg_t  cfg,
  output logic            res_valid,
  output slps_pkg::res_t  res
);

  localparam int unsigned CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  slps_pkg::mode_t         active_mode, active_mode_next, req_mode;
  logic                    animating, animating_next;
  logic [TIMER_BITS-1:0]   since_start_ms, since_start_ms_next, ss_inc;
  logic [TIMER_BITS-1:0]   since_update_ms, since_update_ms_next, su_inc;
  logic [7:0]              breath_level, breath_level_next;
  logic                    breath_rising, breath_rising_next;
  logic [15:0]             cycle_hue, cycle_hue_next;
  logic                    blink_phase, blink_phase_next;
  logic [15:0]             blink_period;
  logic [8:0]              breath_sum;
  logic [16:0]             hue_sum;

  assign ss_inc = (&since_start_ms) ? since_start_ms : since_start_ms + 1'b1;
  assign su_inc = (&since_update_ms) ? since_update_ms : since_update_ms + 1'b1;
  assign req_mode = (new_mode > 4'(slps_pkg::MODE_SERVER_ERR)) ? slps_pkg::MODE_OFF
                                                              : slps_pkg::mode_t'(new_mode);
  assign blink_period = (active_mode == slps_pkg::MODE_CONNECTING) ? cfg.slow_blink_ms
                                                                  : cfg.fast_blink_ms;
  assign breath_sum = {1'b0, breath_level} + {1'b0, slps_pkg::BREATH_STEP};
  assign hue_sum    = {1'b0, cycle_hue} + {1'b0, slps_pkg::HUE_STEP};

  always_comb begin
    active_mode_next     = active_mode;
    animating_next       = animating;
    since_start_ms_next  = since_start_ms;
    since_update_ms_next = since_update_ms;
    breath_level_next    = breath_level;
    breath_rising_next   = breath_rising;
    cycle_hue_next       = cycle_hue;
    blink_phase_next     = blink_phase;
    res_valid            = 1'b0;
    res                  = '0;
    res.current_mode     = active_mode;

    if (req_type) begin
      if (req_mode != active_mode) begin
        active_mode_next     = req_mode;
        since_start_ms_next  = '0;
        since_update_ms_next = '0;
        animating_next       = 1'b1;
        breath_level_next    = '0;
        breath_rising_next   = 1'b1;
        cycle_hue_next       = '0;
        blink_phase_next     = 1'b0;
      end
    end else begin
      since_start_ms_next  = ss_inc;
      since_update_ms_next = su_inc;
      if (CW'(su_inc) >= CW'(cfg.update_interval_ms)) begin
        since_update_ms_next = '0;
        if (animating) begin
          res_valid = 1'b1;
          unique case (active_mode)
            slps_pkg::MODE_BOOTING, slps_pkg::MODE_CONNECTED: begin
              if ((active_mode == slps_pkg::MODE_BOOTING &&
                   CW'(ss_inc) >= CW'(cfg.boot_breath_ms)) ||
                  (active_mode == slps_pkg::MODE_CONNECTED &&
                   CW'(ss_inc) >= CW'(cfg.connected_hold_ms))) begin
                // timeout: drop to off and restart the animation
                res_valid            = 1'b0;
                active_mode_next     = slps_pkg::MODE_OFF;
                since_start_ms_next  = '0;
                animating_next       = 1'b1;
                breath_level_next    = '0;
                breath_rising_next   = 1'b1;
                cycle_hue_next       = '0;
                blink_phase_next     = 1'b0;
              end else if (active_mode == slps_pkg::MODE_BOOTING) begin
                if (breath_rising) begin
                  if (breath_sum >= 9'(slps_pkg::FULL_8)) begin
                    breath_level_next  = slps_pkg::FULL_8;
                    breath_rising_next = 1'b0;
                  end else begin
                    breath_level_next = breath_sum[7:0];
                  end
                end else if (breath_level <= slps_pkg::BREATH_STEP) begin
                  breath_level_next  = '0;
                  breath_rising_next = 1'b1;
                end else begin
                  breath_level_next = breath_level - slps_pkg::BREATH_STEP;
                end
                res.led_on     = 1'b1;
                res.hue        = slps_pkg::HUE_BLUE;
                res.saturation = slps_pkg::FULL_8;
                res.level      = breath_level_next;
              end else begin
                res.led_on     = 1'b1;
                res.hue        = slps_pkg::HUE_GREEN;
                res.saturation = slps_pkg::FULL_8;
                res.level      = slps_pkg::FULL_8;
              end
            end
            slps_pkg::MODE_CONNECTING, slps_pkg::MODE_WIFI_ERR,
            slps_pkg::MODE_SERVER_ERR: begin
              if (CW'(ss_inc) >= CW'(blink_period)) begin
                blink_phase_next    = !blink_phase;
                since_start_ms_next = '0;
              end
              if (blink_phase_next) begin
                res.led_on     = 1'b1;
                res.hue        = (active_mode == slps_pkg::MODE_CONNECTING) ?
                                 slps_pkg::HUE_BLUE : slps_pkg::HUE_RED;
                res.saturation = slps_pkg::FULL_8;
                res.level      = slps_pkg::FULL_8;
              end
            end
            slps_pkg::MODE_OTA: begin
              cycle_hue_next = (hue_sum >= slps_pkg::HUE_WRAP) ? '0 : hue_sum[15:0];
              res.led_on     = 1'b1;
              res.hue        = cycle_hue_next;
              res.saturation = slps_pkg::FULL_8;
              res.level      = slps_pkg::FULL_8;
            end
            slps_pkg::MODE_CARD_READING: begin
              res.led_on     = 1'b1;
              res.hue        = slps_pkg::HUE_YELLOW;
              res.saturation = slps_pkg::FULL_8;
              res.level      = slps_pkg::FULL_8;
            end
            slps_pkg::MODE_CARD_VALID: begin
              res.led_on     = 1'b1;
              res.hue        = slps_pkg::HUE_GREEN;
              res.saturation = slps_pkg::FULL_8;
              res.level      = slps_pkg::FULL_8;
            end
            slps_pkg::MODE_CARD_INVALID: begin
              res.led_on     = 1'b1;
              res.hue        = slps_pkg::HUE_RED;
              res.saturation = slps_pkg::FULL_8;
              res.level      = slps_pkg::FULL_8;
            end
            default: begin
              // off: one dark word, then stop
              animating_next = 1'b0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_mode     <= slps_pkg::MODE_OFF;
      animating       <= 1'b0;
      since_start_ms  <= '0;
      since_update_ms <= '0;
      breath_level    <= '0;
      breath_rising   <= 1'b1;
      cycle_hue       <= '0;
      blink_phase     <= 1'b0;
    end else if (en) begin
      active_mode     <= active_mode_next;
      animating       <= animating_next;
      since_start_ms  <= since_start_ms_next;
      since_update_ms <= since_update_ms_next;
      breath_level    <= breath_level_next;
      breath_rising   <= breath_rising_next;
      cycle_hue       <= cycle_hue_next;
      blink_phase     <= blink_phase_next;
    end
  end

endmodule

// File: design/status_led_pattern_sequencer.sv
// Top level of the status LED pattern sequencer.
// Each input word is a one-millisecond tick or a set-mode request; while animating, ticks that
// reach the update interval yield one hue/saturation/value word, except on a breath or hold
// timeout. One word is taken per clock while the input is not stalled: it waits in the input
// register, is processed in a single pass against the pattern state when it advances, and
// its result is registered in the output register as it advances.
// The input stalls only while the input register holds a word and the output
// register is full and stalled.
module status_led_pattern_sequencer #(
  parameter int unsigned TIMER_BITS = slps_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic [3:0]                        new_mode,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              led_on,
  output logic [15:0]                       hue,
  output logic [7:0]                        saturation,
  output logic [7:0]                        level,
  output logic [3:0]                        current_mode,
  input  logic                              cfg_we,
  input  logic [slps_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [slps_pkg::CFG_DATA_W-1:0]   cfg_data
);

  slps_pkg::cfg_t cfg;
  slps_pkg::res_t res, out_word;
  logic           s_valid, s_req;
  logic [3:0]     s_mode;
  logic           advance, res_valid;

  assign advance  = s_valid && (!out_valid || !out_stall);
  assign in_stall = s_valid && !advance;

  slps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slps_core #(.TIMER_BITS(TIMER_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .req_type  (s_req),
    .new_mode  (s_mode),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_req  <= req_type;
      s_mode <= new_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_word <= res;
    end
  end

  assign led_on       = out_word.led_on;
  assign hue          = out_word.hue;
  assign saturation   = out_word.saturation;
  assign level        = out_word.level;
  assign current_mode = out_word.current_mode;

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s_valid)
    else $error("input stalled with empty input register");

  a_set_mode_silent: assert property (@(posedge clk) disable iff (rst)
    advance && s_req |=> !out_valid)
    else $error("set-mode word produced a result");

  a_dark_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !led_on |-> hue == 16'd0 && saturation == 8'd0 && level == 8'd0)
    else $error("dark result carries colour");

  a_no_result_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule
